FILE: rtl/core/rsbl_pkg.sv
// Shared constants, request and status codes, command/status structs and helpers
// for the rank/select bit vector block. No dependencies.
`timescale 1ns / 1ps

package rsbl_pkg;

    // Geometry of the vector and of the two-level rank directory
    localparam int MAX_BITS    = 65536;
    localparam int SUPER_BITS  = 2048;
    localparam int BLOCK_BITS  = 256;
    localparam int STORE_BYTES = MAX_BITS / 8;
    localparam int NUM_SUPER   = MAX_BITS / SUPER_BITS + 1;
    localparam int NUM_BLOCK   = MAX_BITS / BLOCK_BITS + 1;

    localparam int LEN_W   = 17;                       // lengths, positions, counts
    localparam int BYTE_AW = $clog2(STORE_BYTES);      // byte address
    localparam int PTR_W   = BYTE_AW + 1;              // byte pointer incl. end
    localparam int SUP_AW  = $clog2(NUM_SUPER);
    localparam int BLK_AW  = $clog2(NUM_BLOCK);
    localparam int SUP_SH  = $clog2(SUPER_BITS);       // bit position -> superblock
    localparam int BLK_SH  = $clog2(BLOCK_BITS);       // bit position -> block
    localparam int BLK_BSH = $clog2(BLOCK_BITS / 8);   // byte pointer -> block
    localparam int SUP_BSH = $clog2(SUPER_BITS / 8);   // byte pointer -> superblock
    localparam int WITHIN_W = SUP_SH;                  // count inside one superblock

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BITS);
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    // Request codes
    localparam logic [3:0] REQ_LOAD   = 4'd0;
    localparam logic [3:0] REQ_BUILD  = 4'd1;
    localparam logic [3:0] REQ_RANK1  = 4'd2;
    localparam logic [3:0] REQ_RANK0  = 4'd3;
    localparam logic [3:0] REQ_SEL1   = 4'd4;
    localparam logic [3:0] REQ_SEL0   = 4'd5;
    localparam logic [3:0] REQ_CBEGIN = 4'd6;
    localparam logic [3:0] REQ_CCOUNT = 4'd7;
    localparam logic [3:0] REQ_CHILD  = 4'd8;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_NOTBUILT = 2'd2;

    // Datapath micro-operations
    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_LOAD   = 5'd1;
    localparam logic [4:0] OP_MRD    = 5'd2;
    localparam logic [4:0] OP_MWR    = 5'd3;
    localparam logic [4:0] OP_BRD    = 5'd4;
    localparam logic [4:0] OP_BACC   = 5'd5;
    localparam logic [4:0] OP_BFIN   = 5'd6;
    localparam logic [4:0] OP_RSTART = 5'd7;
    localparam logic [4:0] OP_RBASE  = 5'd8;
    localparam logic [4:0] OP_RRD    = 5'd9;
    localparam logic [4:0] OP_RACC   = 5'd10;
    localparam logic [4:0] OP_SINIT  = 5'd11;
    localparam logic [4:0] OP_SCHK   = 5'd12;
    localparam logic [4:0] OP_SUPD   = 5'd13;
    localparam logic [4:0] OP_SDONE  = 5'd14;
    localparam logic [4:0] OP_SETB   = 5'd15;
    localparam logic [4:0] OP_OUT    = 5'd16;

    // Rank argument sources
    localparam logic [1:0] RS_POS   = 2'd0;
    localparam logic [1:0] RS_LEN   = 2'd1;
    localparam logic [1:0] RS_MID   = 2'd2;
    localparam logic [1:0] RS_CHILD = 2'd3;

    // Select ordinal sources
    localparam logic [1:0] KS_ORD    = 2'd0;
    localparam logic [1:0] KS_NODEM1 = 2'd1;
    localparam logic [1:0] KS_NODE   = 2'd2;

    // Result sources
    localparam logic [2:0] RES_ZERO  = 3'd0;
    localparam logic [2:0] RES_NB    = 3'd1;
    localparam logic [2:0] RES_RANK  = 3'd2;
    localparam logic [2:0] RES_SEL   = 3'd3;
    localparam logic [2:0] RES_BEGIN = 3'd4;
    localparam logic [2:0] RES_COUNT = 3'd5;
    localparam logic [2:0] RES_CHILD = 3'd6;

    typedef struct packed {
        logic       latch;
        logic [4:0] op;
        logic [1:0] rsrc;
        logic       ones;
        logic [1:0] ksrc;
        logic [2:0] res;
    } t_cmd;

    typedef struct packed {
        logic built;
        logic node_zero;
        logic bld_more;
        logic rk_more;
        logic sel_miss;
        logic sel_open;
    } t_stat;

    function automatic logic [3:0] popcnt8(input logic [7:0] b);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++) begin
            c = c + {3'd0, b[i]};
        end
        return c;
    endfunction

    // keep the first frac bits (MSB first) of a byte; frac 0 keeps all
    function automatic logic [7:0] head_mask(input logic [2:0] frac);
        logic [7:0] m;
        m = (frac == 3'd0) ? BYTE_ONES : 8'(BYTE_ONES << (4'd8 - {1'b0, frac}));
        return m;
    endfunction

endpackage

FILE: rtl/core/rsbl_dp.sv
// Datapath: bit store, rank directory memories, build, rank scan and select search
// registers, result register and the length register. Depends on rsbl_pkg.
`timescale 1ns / 1ps

module rsbl_dp import rsbl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [12:0]      i_byte_index,
    input  logic [7:0]       i_byte_value,
    input  logic [16:0]      i_position,
    input  logic [15:0]      i_ordinal,
    input  logic [16:0]      i_node_id,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_wdata,
    input  logic             i_cfg_sel,
    output logic [31:0]      o_cfg_rdata,
    output logic [16:0]      o_value,
    output logic [1:0]       o_status
);

    // memories
    logic [7:0]        r_store [STORE_BYTES];
    logic [LEN_W-1:0]  r_sup   [NUM_SUPER];
    logic [10:0]       r_blk   [NUM_BLOCK];
    logic [7:0]        r_sdata;
    logic [LEN_W-1:0]  r_supd;
    logic [10:0]       r_blkd;

    // control and payload registers
    logic [LEN_W-1:0]  r_len;
    logic              r_built;
    logic [12:0]       r_bidx;
    logic [7:0]        r_bval;
    logic [16:0]       r_pos;
    logic [15:0]       r_ord;
    logic [16:0]       r_node;
    logic [PTR_W-1:0]  r_bb;
    logic [LEN_W-1:0]  r_total;
    logic [WITHIN_W-1:0] r_within;
    logic [LEN_W-1:0]  r_ri;
    logic              r_rones;
    logic [LEN_W-1:0]  r_rcnt;
    logic [PTR_W-1:0]  r_rj;
    logic [PTR_W-1:0]  r_rend;
    logic [LEN_W-1:0]  r_k;
    logic [LEN_W-1:0]  r_lo;
    logic [LEN_W-1:0]  r_hi;
    logic [LEN_W-1:0]  r_sel;
    logic              r_miss;
    logic [LEN_W-1:0]  r_b;
    logic [16:0]       r_value;
    logic [1:0]        r_status;

    logic [LEN_W:0]    len_p7;
    logic [PTR_W-1:0]  nbytes;
    logic [BYTE_AW-1:0] last_byte;
    logic [LEN_W-1:0]  mid;
    logic [LEN_W:0]    rk_arg;
    logic [LEN_W-1:0]  ri_c;
    logic [LEN_W-1:0]  rank_val;
    logic [LEN_W-1:0]  ksel;
    logic [BYTE_AW-1:0] rd_addr;
    logic              bnd_blk;
    logic              bnd_sup;
    logic [WITHIN_W-1:0] within_base;
    logic [3:0]        pc_bld;
    logic [3:0]        pc_rk;
    logic [7:0]        rk_mask;

    // derived build quantities
    assign len_p7    = {1'b0, r_len} + (LEN_W+1)'(7);
    assign nbytes    = len_p7[LEN_W-1:3];
    assign last_byte = BYTE_AW'(nbytes - PTR_W'(1));
    assign mid       = r_lo + ((r_hi - r_lo) >> 1);

    // rank argument and clamp to length
    always_comb begin
        case (i_cmd.rsrc)
            RS_POS:  rk_arg = {1'b0, r_pos};
            RS_LEN:  rk_arg = {1'b0, r_len};
            RS_MID:  rk_arg = {1'b0, mid} + (LEN_W+1)'(1);
            default: rk_arg = {1'b0, r_b} + {2'b0, r_ord};
        endcase
        ri_c = (rk_arg > {1'b0, r_len}) ? r_len : rk_arg[LEN_W-1:0];
    end

    assign rank_val = r_rones ? r_rcnt : (r_ri - r_rcnt);

    // select ordinal source
    always_comb begin
        case (i_cmd.ksrc)
            KS_ORD:    ksel = {1'b0, r_ord};
            KS_NODEM1: ksel = r_node - LEN_W'(1);
            default:   ksel = r_node;
        endcase
    end

    // store read address
    always_comb begin
        case (i_cmd.op)
            OP_MRD:  rd_addr = last_byte;
            OP_BRD:  rd_addr = r_bb[BYTE_AW-1:0];
            default: rd_addr = r_rj[BYTE_AW-1:0];
        endcase
    end

    assign bnd_blk     = (r_bb[BLK_BSH-1:0] == '0);
    assign bnd_sup     = (r_bb[SUP_BSH-1:0] == '0);
    assign within_base = bnd_sup ? '0 : r_within;
    assign pc_bld      = popcnt8(r_sdata);
    assign rk_mask     = (r_rj == r_ri[LEN_W-1:3]) ? head_mask(r_ri[2:0]) : BYTE_ONES;
    assign pc_rk       = popcnt8(r_sdata & rk_mask);

    // bit store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_store[r_bidx] <= r_bval;
        end else if (i_cmd.op == OP_MWR && r_len[2:0] != 3'd0) begin
            r_store[last_byte] <= r_sdata & head_mask(r_len[2:0]);
        end
        if (i_cmd.op == OP_MRD || i_cmd.op == OP_BRD || i_cmd.op == OP_RRD) begin
            r_sdata <= r_store[rd_addr];
        end
    end

    // rank directory memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_BACC) begin
            if (bnd_blk) begin
                r_blk[r_bb[PTR_W-1:BLK_BSH]] <= 11'(within_base);
            end
            if (bnd_sup) begin
                r_sup[r_bb[PTR_W-1:SUP_BSH]] <= r_total;
            end
        end else if (i_cmd.op == OP_BFIN) begin
            if (r_len[BLK_SH-1:0] == '0) begin
                r_blk[r_len[LEN_W-1:BLK_SH]] <=
                    (r_len[SUP_SH-1:0] == '0) ? 11'd0 : 11'(r_within);
            end
            if (r_len[SUP_SH-1:0] == '0) begin
                r_sup[r_len[LEN_W-1:SUP_SH]] <= r_total;
            end
        end
        if (i_cmd.op == OP_RSTART) begin
            r_supd <= r_sup[ri_c[LEN_W-1:SUP_SH]];
            r_blkd <= r_blk[ri_c[LEN_W-1:BLK_SH]];
        end
    end

    // length register and built flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_built <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len   <= (i_cfg_wdata[LEN_W-1:0] > MAX_LEN) ? MAX_LEN :
                           i_cfg_wdata[LEN_W-1:0];
                r_built <= 1'b0;
            end else if (i_cmd.op == OP_LOAD) begin
                r_built <= 1'b0;
            end else if (i_cmd.op == OP_BFIN) begin
                r_built <= 1'b1;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_bidx <= i_byte_index;
            r_bval <= i_byte_value;
            r_pos  <= i_position;
            r_ord  <= i_ordinal;
            r_node <= i_node_id;
        end
        case (i_cmd.op)
            OP_MWR: begin
                r_bb     <= '0;
                r_total  <= '0;
                r_within <= '0;
            end
            OP_BACC: begin
                r_within <= within_base + WITHIN_W'(pc_bld);
                r_total  <= r_total + LEN_W'(pc_bld);
                r_bb     <= r_bb + PTR_W'(1);
            end
            OP_RSTART: begin
                r_ri    <= ri_c;
                r_rones <= i_cmd.ones;
                r_rj    <= {ri_c[LEN_W-1:BLK_SH], BLK_BSH'(0)};
                r_rend  <= ri_c[LEN_W-1:3] + PTR_W'(ri_c[2:0] != 3'd0);
            end
            OP_RBASE: begin
                r_rcnt <= (r_ri == '0) ? '0 : r_supd + LEN_W'(r_blkd);
            end
            OP_RACC: begin
                r_rcnt <= r_rcnt + LEN_W'(pc_rk);
                r_rj   <= r_rj + PTR_W'(1);
            end
            OP_SINIT: begin
                r_k  <= ksel;
                r_lo <= '0;
                r_hi <= r_len;
            end
            OP_SCHK: begin
                r_miss <= o_stat.sel_miss;
                r_sel  <= r_len;
            end
            OP_SUPD: begin
                if (rank_val <= r_k) begin
                    r_lo <= mid + LEN_W'(1);
                end else begin
                    r_hi <= mid;
                end
            end
            OP_SDONE: begin
                r_sel <= r_lo;
            end
            OP_SETB: begin
                r_b <= (r_node == '0) ? '0 : r_sel + LEN_W'(1);
            end
            OP_OUT: begin
                case (i_cmd.res)
                    RES_NB: begin
                        r_value  <= '0;
                        r_status <= ST_NOTBUILT;
                    end
                    RES_RANK: begin
                        r_value  <= rank_val;
                        r_status <= ST_OK;
                    end
                    RES_SEL: begin
                        r_value  <= r_sel;
                        r_status <= r_miss ? ST_MISS : ST_OK;
                    end
                    RES_BEGIN: begin
                        r_value  <= r_b;
                        r_status <= ST_OK;
                    end
                    RES_COUNT: begin
                        r_value  <= (r_sel > r_b) ? r_sel - r_b : '0;
                        r_status <= ST_OK;
                    end
                    RES_CHILD: begin
                        r_value  <= r_rcnt + LEN_W'(1);
                        r_status <= ST_OK;
                    end
                    default: begin
                        r_value  <= '0;
                        r_status <= ST_OK;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // status to controller
    assign o_stat.built     = r_built;
    assign o_stat.node_zero = (r_node == '0);
    assign o_stat.bld_more  = (r_bb < nbytes);
    assign o_stat.rk_more   = (r_rj < r_rend);
    assign o_stat.sel_miss  = (r_k >= rank_val);
    assign o_stat.sel_open  = (r_lo < r_hi);

    assign o_cfg_rdata = i_cfg_sel ? {15'd0, r_len} : 32'd0;
    assign o_value     = r_value;
    assign o_status    = r_status;

endmodule

FILE: rtl/core/rsbl_ctrl.sv
// Controller state machine: sequences load, build, rank, select and LOUDS requests
// as datapath micro-operations, and owns the handshakes. Depends on rsbl_pkg.
`timescale 1ns / 1ps

module rsbl_ctrl import rsbl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_req_type,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_cmd        o_cmd,
    input  t_stat       i_stat
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_LOAD   = 5'd2;
    localparam logic [4:0] S_MRD    = 5'd3;
    localparam logic [4:0] S_MWR    = 5'd4;
    localparam logic [4:0] S_BRD    = 5'd5;
    localparam logic [4:0] S_BACC   = 5'd6;
    localparam logic [4:0] S_BFIN   = 5'd7;
    localparam logic [4:0] S_RSTART = 5'd8;
    localparam logic [4:0] S_RBASE  = 5'd9;
    localparam logic [4:0] S_RRD    = 5'd10;
    localparam logic [4:0] S_RACC   = 5'd11;
    localparam logic [4:0] S_SINIT  = 5'd12;
    localparam logic [4:0] S_SCHK   = 5'd13;
    localparam logic [4:0] S_SLOOP  = 5'd14;
    localparam logic [4:0] S_SUPD   = 5'd15;
    localparam logic [4:0] S_SDONE  = 5'd16;
    localparam logic [4:0] S_SETB   = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0] r_state, n_state;
    logic [3:0] r_type,  n_type;
    logic       r_stage, n_stage;
    logic       r_nb,    n_nb;
    logic [1:0] r_rsrc,  n_rsrc;
    logic [4:0] r_rret,  n_rret;
    logic       r_ovalid, n_ovalid;

    logic       accept;
    logic       out_fire;
    logic [4:0] sel_ret;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_fire = (r_state == S_OUT) && (!r_ovalid || !i_out_stall);

    // where a finished select goes next
    assign sel_ret = (r_type == REQ_SEL1 || r_type == REQ_SEL0 ||
                      (r_type == REQ_CCOUNT && r_stage)) ? S_OUT : S_SETB;

    // next state and command
    always_comb begin
        n_state = r_state;
        n_type  = r_type;
        n_stage = r_stage;
        n_nb    = r_nb;
        n_rsrc  = r_rsrc;
        n_rret  = r_rret;

        o_cmd       = '0;
        o_cmd.latch = accept;
        o_cmd.op    = OP_NOP;
        o_cmd.rsrc  = r_rsrc;
        // child walks zeros for its begin, then counts ones
        o_cmd.ones  = (r_type == REQ_RANK1 || r_type == REQ_SEL1 ||
                       (r_type == REQ_CHILD && r_rsrc == RS_CHILD));
        o_cmd.ksrc  = (r_type == REQ_SEL1 || r_type == REQ_SEL0) ? KS_ORD :
                      (r_type == REQ_CCOUNT && r_stage) ? KS_NODE : KS_NODEM1;
        case (r_type)
            REQ_RANK1, REQ_RANK0: o_cmd.res = RES_RANK;
            REQ_SEL1, REQ_SEL0:   o_cmd.res = RES_SEL;
            REQ_CBEGIN:           o_cmd.res = RES_BEGIN;
            REQ_CCOUNT:           o_cmd.res = RES_COUNT;
            REQ_CHILD:            o_cmd.res = RES_CHILD;
            default:              o_cmd.res = RES_ZERO;
        endcase
        if (r_nb) begin
            o_cmd.res = RES_NB;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_type  = i_req_type;
                    n_stage = 1'b0;
                    n_nb    = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (r_type == REQ_LOAD) begin
                    n_state = S_LOAD;
                end else if (r_type == REQ_BUILD) begin
                    n_state = S_MRD;
                end else if (r_type > REQ_CHILD) begin
                    n_state = S_OUT;
                end else if (!i_stat.built) begin
                    n_nb    = 1'b1;
                    n_state = S_OUT;
                end else begin
                    case (r_type) inside
                        REQ_RANK1, REQ_RANK0: begin
                            n_rsrc  = RS_POS;
                            n_rret  = S_OUT;
                            n_state = S_RSTART;
                        end
                        REQ_SEL1, REQ_SEL0: n_state = S_SINIT;
                        default: n_state = i_stat.node_zero ? S_SETB : S_SINIT;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state  = S_OUT;
            end
            S_MRD: begin
                o_cmd.op = OP_MRD;
                n_state  = S_MWR;
            end
            S_MWR: begin
                o_cmd.op = OP_MWR;
                n_state  = S_BRD;
            end
            S_BRD: begin
                if (i_stat.bld_more) begin
                    o_cmd.op = OP_BRD;
                    n_state  = S_BACC;
                end else begin
                    n_state = S_BFIN;
                end
            end
            S_BACC: begin
                o_cmd.op = OP_BACC;
                n_state  = S_BRD;
            end
            S_BFIN: begin
                o_cmd.op = OP_BFIN;
                n_state  = S_OUT;
            end
            S_RSTART: begin
                o_cmd.op = OP_RSTART;
                n_state  = S_RBASE;
            end
            S_RBASE: begin
                o_cmd.op = OP_RBASE;
                n_state  = S_RRD;
            end
            S_RRD: begin
                if (i_stat.rk_more) begin
                    o_cmd.op = OP_RRD;
                    n_state  = S_RACC;
                end else begin
                    n_state = r_rret;
                end
            end
            S_RACC: begin
                o_cmd.op = OP_RACC;
                n_state  = S_RRD;
            end
            S_SINIT: begin
                o_cmd.op = OP_SINIT;
                n_rsrc   = RS_LEN;
                n_rret   = S_SCHK;
                n_state  = S_RSTART;
            end
            S_SCHK: begin
                o_cmd.op = OP_SCHK;
                n_state  = i_stat.sel_miss ? sel_ret : S_SLOOP;
            end
            S_SLOOP: begin
                if (i_stat.sel_open) begin
                    n_rsrc  = RS_MID;
                    n_rret  = S_SUPD;
                    n_state = S_RSTART;
                end else begin
                    n_state = S_SDONE;
                end
            end
            S_SUPD: begin
                o_cmd.op = OP_SUPD;
                n_state  = S_SLOOP;
            end
            S_SDONE: begin
                o_cmd.op = OP_SDONE;
                n_state  = sel_ret;
            end
            S_SETB: begin
                o_cmd.op = OP_SETB;
                if (r_type == REQ_CCOUNT) begin
                    n_stage = 1'b1;
                    n_state = S_SINIT;
                end else if (r_type == REQ_CHILD) begin
                    n_rsrc  = RS_CHILD;
                    n_rret  = S_OUT;
                    n_state = S_RSTART;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_fire) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output valid: set on a new result, cleared when taken
    always_comb begin
        n_ovalid = r_ovalid;
        if (out_fire) begin
            n_ovalid = 1'b1;
        end else if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_type   <= REQ_LOAD;
            r_stage  <= 1'b0;
            r_nb     <= 1'b0;
            r_rsrc   <= RS_POS;
            r_rret   <= S_OUT;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_type   <= n_type;
            r_stage  <= n_stage;
            r_nb     <= n_nb;
            r_rsrc   <= n_rsrc;
            r_rret   <= n_rret;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

FILE: rtl/core/rank_select_bitvector_louds.sv
// Top level of the rank/select bit vector with LOUDS navigation: joins the
// controller and the datapath and presents the APB-style register port. Uses rsbl_pkg.
`timescale 1ns / 1ps

// Usage
//   Request channel (i_in_valid / o_in_stall): one request at a time; o_in_stall is
//   high from the cycle after acceptance until the result is written to the output
//   register. Load first sets vector_length over the register port, loads every byte
//   in range (request 0), then builds (request 1). Queries before a build return
//   status 2.
//   Result channel (o_out_valid / i_out_stall): exactly one result per request, held
//   stable while stalled; the next request is accepted while a result still waits.
//   Build reads the loaded bytes one at a time through the single bit-store read port.
//   A rank probe scans b <= 32 bytes inside one 256-bit block, one byte per read of
//   the store. Select runs one probe on the length and up to 17 search probes;
//   child count runs up to two selects; child runs up to one select and a rank.
//   Reset (synchronous, active low) clears vector_length, the built flag and the
//   output valid flag; the result register, store and directory keep no reset.

module rank_select_bitvector_louds import rsbl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_req_type,
    input  logic [12:0] i_byte_index,
    input  logic [7:0]  i_byte_value,
    input  logic [16:0] i_position,
    input  logic [15:0] i_ordinal,
    input  logic [16:0] i_node_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [16:0] o_value,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;

    // register write at the access phase, only register 0 exists
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    rsbl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    rsbl_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_byte_index (i_byte_index),
        .i_byte_value (i_byte_value),
        .i_position   (i_position),
        .i_ordinal    (i_ordinal),
        .i_node_id    (i_node_id),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (pwdata),
        .i_cfg_sel    (paddr[2] == 1'b0),
        .o_cfg_rdata  (prdata),
        .o_value      (o_value),
        .o_status     (o_status)
    );

endmodule

FILE: rtl/core/rsbl_checker.sv
// Port-level checks for rank_select_bitvector_louds, attached by bind.
// Depends on rsbl_pkg for status codes.
`timescale 1ns / 1ps

module rsbl_checker import rsbl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [16:0] o_value,
    input logic [1:0]  o_status
);

    // one request at a time: an accepted request blocks the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while previous one in flight");

    // status code is one of the defined ones
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_MISS ||
                         o_status == ST_NOTBUILT))
        else $error("undefined status code");

    // a stalled result stays valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result stays unchanged
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_value) && $stable(o_status))
        else $error("result changed while stalled");

endmodule

bind rank_select_bitvector_louds rsbl_checker u_rsbl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value     (o_value),
    .o_status    (o_status)
);
